// File: rtl/rsvm_pkg.sv
// ----------------------------------------------------------------------------
// rsvm_pkg: shared constants, codes and helpers of the register/stack vm core
// Sizes, opcode and operand kind codes, the shared alu and branch conditions.
// ----------------------------------------------------------------------------
package rsvm_pkg;

   localparam int PROGRAM_DEPTH       = 1024;
   localparam int DATA_WORDS          = 1024;
   localparam int OPERAND_STACK_DEPTH = 256;
   localparam int RETURN_STACK_DEPTH  = 64;
   localparam int LABEL_COUNT         = 256;
   localparam int MAX_POINTER_NESTING = 4;

   localparam int WORD_W = 32;
   localparam int PA_W   = $clog2(PROGRAM_DEPTH);
   localparam int PL_W   = $clog2(PROGRAM_DEPTH + 1);
   localparam int DA_W   = $clog2(DATA_WORDS);
   localparam int SA_W   = $clog2(OPERAND_STACK_DEPTH);
   localparam int SD_W   = $clog2(OPERAND_STACK_DEPTH + 1);
   localparam int RA_W   = $clog2(RETURN_STACK_DEPTH);
   localparam int RD_W   = $clog2(RETURN_STACK_DEPTH + 1);
   localparam int LA_W   = $clog2(LABEL_COUNT);
   localparam int PN_W   = $clog2(MAX_POINTER_NESTING + 1);

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type OPC_MOV    = 32'd0;
   localparam word_type OPC_LABEL  = 32'd1;
   localparam word_type OPC_ADD    = 32'd2;
   localparam word_type OPC_SUB    = 32'd3;
   localparam word_type OPC_MUL    = 32'd4;
   localparam word_type OPC_DIV    = 32'd5;
   localparam word_type OPC_CMP    = 32'd6;
   localparam word_type OPC_AND    = 32'd7;
   localparam word_type OPC_OR     = 32'd8;
   localparam word_type OPC_XOR    = 32'd9;
   localparam word_type OPC_NOT    = 32'd10;
   localparam word_type OPC_JMP    = 32'd11;
   localparam word_type OPC_CAL    = 32'd18;
   localparam word_type OPC_CGE    = 32'd24;
   localparam word_type OPC_NATIVE = 32'd25;
   localparam word_type OPC_RET    = 32'd26;
   localparam word_type OPC_EXIT   = 32'd27;
   localparam word_type OPC_PRINT  = 32'd28;
   localparam word_type OPC_INPUT  = 32'd29;

   localparam word_type KIND_R1    = 32'h00;
   localparam word_type KIND_R2    = 32'h01;
   localparam word_type KIND_CMPR  = 32'h02;
   localparam word_type KIND_MEM   = 32'h10;
   localparam word_type KIND_STACK = 32'h20;
   localparam word_type KIND_PTR   = 32'h30;
   localparam word_type KIND_CONST = 32'h40;

   localparam logic [2:0] COND_ALWAYS = 3'd0;
   localparam logic [2:0] COND_EQ     = 3'd1;
   localparam logic [2:0] COND_NE     = 3'd2;
   localparam logic [2:0] COND_LT     = 3'd3;
   localparam logic [2:0] COND_GT     = 3'd4;
   localparam logic [2:0] COND_LE     = 3'd5;

   function automatic word_type alu_calc(input word_type opc, input word_type a,
                                         input word_type b);
      word_type r;
      case (opc)
         OPC_ADD: r = a + b;
         OPC_SUB: r = a - b;
         OPC_CMP: r = a - b;
         OPC_MUL: r = a * b;
         OPC_AND: r = a & b;
         OPC_OR:  r = a | b;
         OPC_XOR: r = a ^ b;
         default: r = a;
      endcase
      return r;
   endfunction

   function automatic logic cond_holds(input logic [2:0] code, input word_type c);
      logic z;
      logic n;
      logic r;
      z = (c == '0);
      n = c[WORD_W-1];
      case (code)
         COND_ALWAYS: r = 1'b1;
         COND_EQ:     r = z;
         COND_NE:     r = !z;
         COND_LT:     r = n;
         COND_GT:     r = !n && !z;
         COND_LE:     r = n || z;
         default:     r = !n;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/rsvm_div.sv
// ----------------------------------------------------------------------------
// rsvm_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rsvm_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  rsvm_pkg::word_type       dividend,
   input  rsvm_pkg::word_type       divisor,
   output logic                     done,
   output rsvm_pkg::word_type       quotient
);

   localparam int CNT_W = $clog2(rsvm_pkg::WORD_W);

   logic                         busy_ff;
   logic                         done_ff;
   logic                         neg_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [rsvm_pkg::WORD_W:0]    rem_ff;
   rsvm_pkg::word_type           quo_ff;
   rsvm_pkg::word_type           den_ff;
   logic [rsvm_pkg::WORD_W:0]    rem_sh;
   logic [rsvm_pkg::WORD_W:0]    diff;

   assign rem_sh = {rem_ff[rsvm_pkg::WORD_W-1:0], quo_ff[rsvm_pkg::WORD_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            neg_ff  <= dividend[rsvm_pkg::WORD_W-1] ^ divisor[rsvm_pkg::WORD_W-1];
            quo_ff  <= dividend[rsvm_pkg::WORD_W-1] ? (0 - dividend) : dividend;
            den_ff  <= divisor[rsvm_pkg::WORD_W-1] ? (0 - divisor) : divisor;
         end else if (busy_ff) begin
            if (!diff[rsvm_pkg::WORD_W]) begin
               rem_ff <= diff;
               quo_ff <= {quo_ff[rsvm_pkg::WORD_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[rsvm_pkg::WORD_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(rsvm_pkg::WORD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (0 - quo_ff) : quo_ff;

endmodule

// File: rtl/register_stack_vm_core.sv
// ----------------------------------------------------------------------------
// register_stack_vm_core: small register and stack virtual machine
// Loads a program word by word and executes one instruction per step word.
// ----------------------------------------------------------------------------
// Input channel req_*: tuser[0] selects the word's kind (0 load a program
// word, 1 execute one instruction); tdata carries the program word or the
// value taken by an input instruction. Every input word yields exactly one
// result word on rsp_*: printed flag, printed value, input-taken flag, and the
// halted and fault flags as they stand after the word.
// A step fetches its program words one at a time from a single-port program
// store with registered read; data memory and stack reads are registered as
// well, and a divide runs on the iterative divider.
// One word is worked on at a time: req_tready is high only while idle.
// After reset all 1024 data memory entries are cleared, one entry per cycle,
// with req_tready low. A finished result is held in an output register; the
// next input word is accepted while it waits, and a new result is held back
// until rsp_tready takes the old one.
// ----------------------------------------------------------------------------
module register_stack_vm_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // word
   input  logic [0:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // printed, print_value, took_input, halted, fault
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_FETCH, ST_FWAIT, ST_OPC,
      ST_GKIND, ST_GDISP, ST_GADDR, ST_GSTK, ST_GCONST, ST_GUNW, ST_MWAIT,
      ST_GOTA, ST_GOTB, ST_ALU, ST_DIV,
      ST_PKIND, ST_PDISP, ST_PMEM, ST_PPTR,
      ST_JID, ST_JLBL, ST_RWAIT, ST_FIN
   } state_type;

   state_type state_ff;
   state_type fret_ff;
   state_type gret_ff;

   logic [rsvm_pkg::PL_W-1:0]      len_ff;
   logic [rsvm_pkg::PL_W-1:0]      ip_ff;
   logic [rsvm_pkg::SD_W-1:0]      od_ff;
   logic [rsvm_pkg::RD_W-1:0]      rd_ff;
   logic [rsvm_pkg::PN_W-1:0]      pcnt_ff;
   logic [rsvm_pkg::DA_W-1:0]      clr_ff;
   logic [rsvm_pkg::LABEL_COUNT-1:0] lv_ff;
   logic                           gstart_ff;
   logic                           last_one_ff;
   logic                           stop_ff;
   logic                           fault_ff;
   logic                           prn_ff;
   logic                           took_ff;
   logic                           rsp_valid_ff;
   logic [39:0]                    rsp_data_ff;
   rsvm_pkg::word_type             r1_ff, r2_ff, cmp_ff;
   rsvm_pkg::word_type             fw_ff, val_ff, a_ff, res_ff, pval_ff, word_ff, opc_ff;

   rsvm_pkg::word_type pmem [rsvm_pkg::PROGRAM_DEPTH];
   rsvm_pkg::word_type dmem [rsvm_pkg::DATA_WORDS];
   rsvm_pkg::word_type smem [rsvm_pkg::OPERAND_STACK_DEPTH];
   logic [rsvm_pkg::PL_W-1:0] rmem [rsvm_pkg::RETURN_STACK_DEPTH];
   logic [rsvm_pkg::PL_W-1:0] lmem [rsvm_pkg::LABEL_COUNT];

   rsvm_pkg::word_type        pm_q, dm_q, sm_q;
   logic [rsvm_pkg::PL_W-1:0] rm_q, lm_q;

   logic                      accept, load_go, pm_we, lm_we, sm_we, rm_we, dm_we;
   logic                      dm_bad, jhold, is_call, ptr_over, div_start, div_done;
   logic [2:0]                jcode;
   rsvm_pkg::word_type        dm_ra32, dm_wdata, alu_res, div_q;
   logic [rsvm_pkg::DA_W-1:0] dm_waddr;
   logic [rsvm_pkg::PL_W-1:0] lbl_target;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign load_go    = accept && !req_tuser[0] &&
                       (len_ff < rsvm_pkg::PL_W'(rsvm_pkg::PROGRAM_DEPTH));
   assign pm_we      = load_go;
   assign lm_we      = load_go && last_one_ff &&
                       (req_tdata < 32'(rsvm_pkg::LABEL_COUNT));

   assign dm_ra32 = (state_ff == ST_GADDR) ? fw_ff : val_ff;
   assign dm_bad  = dm_ra32 >= 32'(rsvm_pkg::DATA_WORDS);

   assign jcode   = (opc_ff < rsvm_pkg::OPC_CAL) ? 3'(opc_ff - rsvm_pkg::OPC_JMP)
                                                 : 3'(opc_ff - rsvm_pkg::OPC_CAL);
   assign is_call = (opc_ff >= rsvm_pkg::OPC_CAL);
   assign jhold   = rsvm_pkg::cond_holds(jcode, cmp_ff);
   assign alu_res = rsvm_pkg::alu_calc(opc_ff, a_ff, val_ff);
   assign ptr_over = ({{rsvm_pkg::PN_W{1'b0}}, gstart_ff} + {1'b0, pcnt_ff})
                     >= (rsvm_pkg::PN_W + 1)'(rsvm_pkg::MAX_POINTER_NESTING);
   assign lbl_target = lv_ff[fw_ff[rsvm_pkg::LA_W-1:0]] ? lm_q : '0;

   assign sm_we = (state_ff == ST_PDISP) && (fw_ff == rsvm_pkg::KIND_STACK) &&
                  (od_ff < rsvm_pkg::SD_W'(rsvm_pkg::OPERAND_STACK_DEPTH));
   assign rm_we = (state_ff == ST_JID) && jhold && is_call &&
                  (rd_ff < rsvm_pkg::RD_W'(rsvm_pkg::RETURN_STACK_DEPTH));
   assign div_start = (state_ff == ST_GOTB) && (opc_ff == rsvm_pkg::OPC_DIV) &&
                      (val_ff != '0);

   always_comb begin
      dm_we    = 1'b0;
      dm_waddr = fw_ff[rsvm_pkg::DA_W-1:0];
      dm_wdata = res_ff;
      case (state_ff)
         ST_CLEAR: begin
            dm_we    = 1'b1;
            dm_waddr = clr_ff;
            dm_wdata = '0;
         end
         ST_PMEM: begin
            dm_we = fw_ff < 32'(rsvm_pkg::DATA_WORDS);
         end
         ST_PPTR: begin
            dm_we    = val_ff < 32'(rsvm_pkg::DATA_WORDS);
            dm_waddr = val_ff[rsvm_pkg::DA_W-1:0];
         end
         default: dm_we = 1'b0;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (pm_we) begin
         pmem[len_ff[rsvm_pkg::PA_W-1:0]] <= req_tdata;
      end
      pm_q <= pmem[ip_ff[rsvm_pkg::PA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dmem[dm_waddr] <= dm_wdata;
      end
      dm_q <= dmem[dm_ra32[rsvm_pkg::DA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (sm_we) begin
         smem[od_ff[rsvm_pkg::SA_W-1:0]] <= res_ff;
      end
      sm_q <= smem[rsvm_pkg::SA_W'(od_ff - 1'b1)];
   end

   always_ff @(posedge clock) begin
      if (rm_we) begin
         rmem[rd_ff[rsvm_pkg::RA_W-1:0]] <= ip_ff;
      end
      rm_q <= rmem[rsvm_pkg::RA_W'(rd_ff - 1'b1)];
   end

   always_ff @(posedge clock) begin
      if (lm_we) begin
         lmem[req_tdata[rsvm_pkg::LA_W-1:0]] <= rsvm_pkg::PL_W'(len_ff + 1'b1);
      end
      lm_q <= lmem[fw_ff[rsvm_pkg::LA_W-1:0]];
   end

   rsvm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (val_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         fret_ff      <= ST_IDLE;
         gret_ff      <= ST_IDLE;
         clr_ff       <= '0;
         len_ff       <= '0;
         ip_ff        <= '0;
         od_ff        <= '0;
         rd_ff        <= '0;
         pcnt_ff      <= '0;
         gstart_ff    <= 1'b0;
         lv_ff        <= '0;
         last_one_ff  <= 1'b0;
         stop_ff      <= 1'b0;
         fault_ff     <= 1'b0;
         r1_ff        <= '0;
         r2_ff        <= '0;
         cmp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (lm_we) begin
            lv_ff[req_tdata[rsvm_pkg::LA_W-1:0]] <= 1'b1;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == rsvm_pkg::DA_W'(rsvm_pkg::DATA_WORDS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  word_ff  <= req_tdata;
                  prn_ff   <= 1'b0;
                  took_ff  <= 1'b0;
                  pval_ff  <= '0;
                  state_ff <= ST_FIN;
                  if (!req_tuser[0]) begin
                     if (load_go) begin
                        len_ff      <= len_ff + 1'b1;
                        last_one_ff <= (req_tdata == 32'd1);
                     end
                  end else if (!stop_ff && !fault_ff) begin
                     if (last_one_ff) begin
                        // dangling label mark
                        fault_ff <= 1'b1;
                     end else begin
                        fret_ff  <= ST_OPC;
                        state_ff <= ST_FETCH;
                     end
                  end
               end
            end
            ST_FETCH: begin
               if (ip_ff >= len_ff) begin
                  fw_ff    <= rsvm_pkg::OPC_EXIT;
                  stop_ff  <= 1'b1;
                  state_ff <= fret_ff;
               end else begin
                  ip_ff    <= ip_ff + 1'b1;
                  state_ff <= ST_FWAIT;
               end
            end
            ST_FWAIT: begin
               fw_ff    <= pm_q;
               state_ff <= fret_ff;
            end
            ST_OPC: begin
               opc_ff    <= fw_ff;
               pcnt_ff   <= '0;
               gstart_ff <= 1'b0;
               gret_ff   <= ST_GOTA;
               state_ff  <= ST_FIN;
               case (fw_ff)
                  rsvm_pkg::OPC_MOV, rsvm_pkg::OPC_ADD, rsvm_pkg::OPC_SUB,
                  rsvm_pkg::OPC_MUL, rsvm_pkg::OPC_DIV, rsvm_pkg::OPC_CMP,
                  rsvm_pkg::OPC_AND, rsvm_pkg::OPC_OR, rsvm_pkg::OPC_XOR,
                  rsvm_pkg::OPC_NOT, rsvm_pkg::OPC_PRINT: begin
                     state_ff <= ST_GKIND;
                  end
                  rsvm_pkg::OPC_LABEL: begin
                     fret_ff  <= ST_FIN;
                     state_ff <= ST_FETCH;
                  end
                  rsvm_pkg::OPC_NATIVE: begin
                     state_ff <= ST_FIN;
                  end
                  rsvm_pkg::OPC_RET: begin
                     if (rd_ff == '0) begin
                        fault_ff <= 1'b1;
                        ip_ff    <= '0;
                     end else begin
                        rd_ff    <= rd_ff - 1'b1;
                        state_ff <= ST_RWAIT;
                     end
                  end
                  rsvm_pkg::OPC_EXIT: begin
                     stop_ff <= 1'b1;
                  end
                  rsvm_pkg::OPC_INPUT: begin
                     took_ff  <= 1'b1;
                     res_ff   <= word_ff;
                     state_ff <= ST_PKIND;
                  end
                  default: begin
                     if (fw_ff >= rsvm_pkg::OPC_JMP && fw_ff <= rsvm_pkg::OPC_CGE) begin
                        fret_ff  <= ST_JID;
                        state_ff <= ST_FETCH;
                     end
                  end
               endcase
            end
            ST_GKIND: begin
               fret_ff  <= ST_GDISP;
               state_ff <= ST_FETCH;
            end
            ST_GDISP: begin
               state_ff <= ST_GUNW;
               case (fw_ff)
                  rsvm_pkg::KIND_R1:   val_ff <= r1_ff;
                  rsvm_pkg::KIND_R2:   val_ff <= r2_ff;
                  rsvm_pkg::KIND_CMPR: val_ff <= cmp_ff;
                  rsvm_pkg::KIND_MEM: begin
                     fret_ff  <= ST_GADDR;
                     state_ff <= ST_FETCH;
                  end
                  rsvm_pkg::KIND_STACK: begin
                     if (od_ff == '0) begin
                        fault_ff <= 1'b1;
                        val_ff   <= '0;
                     end else begin
                        od_ff    <= od_ff - 1'b1;
                        state_ff <= ST_GSTK;
                     end
                  end
                  rsvm_pkg::KIND_PTR: begin
                     if (ptr_over) begin
                        fault_ff <= 1'b1;
                        val_ff   <= '0;
                     end else begin
                        pcnt_ff  <= pcnt_ff + 1'b1;
                        state_ff <= ST_GKIND;
                     end
                  end
                  rsvm_pkg::KIND_CONST: begin
                     fret_ff  <= ST_GCONST;
                     state_ff <= ST_FETCH;
                  end
                  default: val_ff <= '0;
               endcase
            end
            ST_GSTK: begin
               val_ff   <= sm_q;
               state_ff <= ST_GUNW;
            end
            ST_GCONST: begin
               val_ff   <= fw_ff;
               state_ff <= ST_GUNW;
            end
            ST_GADDR: begin
               if (dm_bad) begin
                  fault_ff <= 1'b1;
                  val_ff   <= '0;
                  state_ff <= ST_GUNW;
               end else begin
                  state_ff <= ST_MWAIT;
               end
            end
            ST_GUNW: begin
               // one data read per pointer level, innermost first
               if (pcnt_ff != '0) begin
                  pcnt_ff <= pcnt_ff - 1'b1;
                  if (dm_bad) begin
                     fault_ff <= 1'b1;
                     val_ff   <= '0;
                  end else begin
                     state_ff <= ST_MWAIT;
                  end
               end else begin
                  state_ff <= gret_ff;
               end
            end
            ST_MWAIT: begin
               val_ff   <= dm_q;
               state_ff <= ST_GUNW;
            end
            ST_GOTA: begin
               a_ff <= val_ff;
               case (opc_ff)
                  rsvm_pkg::OPC_MOV: begin
                     res_ff   <= val_ff;
                     state_ff <= ST_PKIND;
                  end
                  rsvm_pkg::OPC_NOT: begin
                     res_ff   <= {31'd0, (val_ff == '0)};
                     state_ff <= ST_PKIND;
                  end
                  rsvm_pkg::OPC_PRINT: begin
                     prn_ff   <= 1'b1;
                     pval_ff  <= val_ff;
                     state_ff <= ST_FIN;
                  end
                  default: begin
                     gret_ff  <= ST_GOTB;
                     state_ff <= ST_GKIND;
                  end
               endcase
            end
            ST_GOTB: begin
               if (opc_ff == rsvm_pkg::OPC_DIV) begin
                  if (val_ff == '0) begin
                     fault_ff <= 1'b1;
                     res_ff   <= '0;
                     state_ff <= ST_PKIND;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end else begin
                  state_ff <= ST_ALU;
               end
            end
            ST_ALU: begin
               if (opc_ff == rsvm_pkg::OPC_CMP) begin
                  cmp_ff   <= alu_res;
                  state_ff <= ST_FIN;
               end else begin
                  res_ff   <= alu_res;
                  state_ff <= ST_PKIND;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  res_ff   <= div_q;
                  state_ff <= ST_PKIND;
               end
            end
            ST_PKIND: begin
               fret_ff  <= ST_PDISP;
               state_ff <= ST_FETCH;
            end
            ST_PDISP: begin
               state_ff <= ST_FIN;
               case (fw_ff)
                  rsvm_pkg::KIND_R1:   r1_ff  <= res_ff;
                  rsvm_pkg::KIND_R2:   r2_ff  <= res_ff;
                  rsvm_pkg::KIND_CMPR: cmp_ff <= res_ff;
                  rsvm_pkg::KIND_MEM: begin
                     fret_ff  <= ST_PMEM;
                     state_ff <= ST_FETCH;
                  end
                  rsvm_pkg::KIND_STACK: begin
                     if (sm_we) begin
                        od_ff <= od_ff + 1'b1;
                     end else begin
                        fault_ff <= 1'b1;
                     end
                  end
                  rsvm_pkg::KIND_PTR: begin
                     // address chain starts one level deep
                     gstart_ff <= 1'b1;
                     pcnt_ff   <= '0;
                     gret_ff   <= ST_PPTR;
                     state_ff  <= ST_GKIND;
                  end
                  default: state_ff <= ST_FIN;
               endcase
            end
            ST_PMEM: begin
               if (!dm_we) begin
                  fault_ff <= 1'b1;
               end
               state_ff <= ST_FIN;
            end
            ST_PPTR: begin
               if (!dm_we) begin
                  fault_ff <= 1'b1;
               end
               state_ff <= ST_FIN;
            end
            ST_JID: begin
               state_ff <= ST_FIN;
               if (jhold) begin
                  if (is_call) begin
                     if (rm_we) begin
                        rd_ff <= rd_ff + 1'b1;
                     end else begin
                        fault_ff <= 1'b1;
                     end
                  end
                  if (fw_ff >= 32'(rsvm_pkg::LABEL_COUNT)) begin
                     fault_ff <= 1'b1;
                     ip_ff    <= '0;
                  end else begin
                     state_ff <= ST_JLBL;
                  end
               end
            end
            ST_JLBL: begin
               if (lbl_target == '0) begin
                  fault_ff <= 1'b1;
               end
               ip_ff    <= lbl_target;
               state_ff <= ST_FIN;
            end
            ST_RWAIT: begin
               ip_ff    <= rm_q;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {4'd0, fault_ff, stop_ff, took_ff, pval_ff, prn_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_ip_in_program: assert property (@(posedge clock) disable iff (reset)
      ip_ff <= len_ff)
      else $error("instruction pointer beyond program length");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      od_ff <= rsvm_pkg::SD_W'(rsvm_pkg::OPERAND_STACK_DEPTH))
      else $error("operand stack depth out of range");

   a_nesting_bound: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= rsvm_pkg::PN_W'(rsvm_pkg::MAX_POINTER_NESTING))
      else $error("pointer nesting count out of range");

   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff |=> fault_ff)
      else $error("fault flag cleared without reset");

   a_div_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside a divide");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for register_stack_vm_core
// Loads program fragments word by word and steps through them, predicting
// every result word with a behavioral copy of the machine, then ends the
// program with one fault or stop case and fills the program store.
// ----------------------------------------------------------------------------
module tb_top;
   import rsvm_pkg::*;

   localparam word_type OPC_UNKNOWN = 32'd30;
   localparam word_type KIND_BAD    = 32'h55;
   localparam int       LOAD_OP     = 0;
   localparam int       STEP_OP     = 1;

   typedef struct packed {
      logic     printed;
      word_type print_value;
      logic     took_input;
      logic     halted;
      logic     fault;
   } vm_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // word
   logic [0:0]  req_tuser = '0;   // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // printed, print_value, took_input, halted, fault

   register_stack_vm_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // machine state as predicted
   word_type    pm_store [PROGRAM_DEPTH];
   int unsigned pm_len;
   int unsigned pc;
   int unsigned lbl_tab [LABEL_COUNT];
   word_type    dmem [DATA_WORDS];
   word_type    ostk [OPERAND_STACK_DEPTH];
   int unsigned odepth;
   int unsigned rstk [RETURN_STACK_DEPTH];
   int unsigned rdepth;
   word_type    reg_a, reg_b, cmp_reg;
   logic        halted_q, fault_q;

   vm_result_t  expected_results[$];
   int          errors = 0;
   int          send_idle_pct = 7;
   int          recv_idle_pct = 77;
   int          n_loads = 0, n_steps = 0, n_checked = 0;
   int          gen_stack;
   int          label_seq = 0;
   int          final_case;

   // ---------------------------------------------------------------- predictor
   function automatic word_type vm_fetch();
      if (pc >= pm_len) begin
         halted_q = 1'b1;
         return OPC_EXIT;
      end
      pc++;
      return pm_store[pc-1];
   endfunction

   function automatic word_type mem_load(word_type addr);
      if (addr >= DATA_WORDS) begin
         fault_q = 1'b1;
         return '0;
      end
      return dmem[addr];
   endfunction

   function automatic void mem_store(word_type addr, word_type v);
      if (addr >= DATA_WORDS) fault_q = 1'b1;
      else dmem[addr] = v;
   endfunction

   function automatic word_type vm_read(int lvl);
      word_type k;
      word_type v;
      k = vm_fetch();
      v = '0;
      case (k)
         KIND_R1:    v = reg_a;
         KIND_R2:    v = reg_b;
         KIND_CMPR:  v = cmp_reg;
         KIND_MEM:   v = mem_load(vm_fetch());
         KIND_STACK: begin
            if (odepth == 0) fault_q = 1'b1;
            else begin
               odepth--;
               v = ostk[odepth];
            end
         end
         KIND_PTR: begin
            if (lvl + 1 > MAX_POINTER_NESTING) fault_q = 1'b1;
            else v = mem_load(vm_read(lvl + 1));
         end
         KIND_CONST: v = vm_fetch();
         default:    v = '0;
      endcase
      return v;
   endfunction

   function automatic void vm_write(word_type v);
      word_type k;
      k = vm_fetch();
      case (k)
         KIND_R1:    reg_a = v;
         KIND_R2:    reg_b = v;
         KIND_CMPR:  cmp_reg = v;
         KIND_MEM:   mem_store(vm_fetch(), v);
         KIND_STACK: begin
            if (odepth >= OPERAND_STACK_DEPTH) fault_q = 1'b1;
            else begin
               ostk[odepth] = v;
               odepth++;
            end
         end
         KIND_PTR:   mem_store(vm_read(1), v);
         default: ;
      endcase
   endfunction

   function automatic int unsigned label_addr(word_type id);
      if (id >= LABEL_COUNT || lbl_tab[id] == 0) begin
         fault_q = 1'b1;
         return 0;
      end
      return lbl_tab[id];
   endfunction

   function automatic logic cond_true(int code);
      logic signed [31:0] c;
      c = cmp_reg;
      case (code)
         COND_ALWAYS: return 1'b1;
         COND_EQ:     return c == 0;
         COND_NE:     return c != 0;
         COND_LT:     return c < 0;
         COND_GT:     return c > 0;
         COND_LE:     return c <= 0;
         default:     return c >= 0;
      endcase
   endfunction

   function automatic word_type signed_quot(word_type a, word_type b);
      if (b == 0) begin
         fault_q = 1'b1;
         return '0;
      end
      if (a == 32'h8000_0000 && b == 32'hffff_ffff) return a;
      return $signed(a) / $signed(b);
   endfunction

   function automatic vm_result_t vm_execute_word(logic op, word_type w);
      vm_result_t r;
      word_type   opc, a, b, id;
      r = '0;
      if (op == LOAD_OP) begin
         if (pm_len < PROGRAM_DEPTH) begin
            if (pm_len > 0 && pm_store[pm_len-1] == OPC_LABEL && w < LABEL_COUNT)
               lbl_tab[w] = pm_len + 1;
            pm_store[pm_len] = w;
            pm_len++;
         end
      end else if (!halted_q && !fault_q) begin
         if (pm_len > 0 && pm_store[pm_len-1] == OPC_LABEL) fault_q = 1'b1;
         else begin
            opc = vm_fetch();
            if (opc >= OPC_JMP && opc < OPC_CAL) begin
               id = vm_fetch();
               if (cond_true(opc - OPC_JMP)) pc = label_addr(id);
            end else if (opc >= OPC_CAL && opc <= OPC_CGE) begin
               id = vm_fetch();
               if (cond_true(opc - OPC_CAL)) begin
                  if (rdepth >= RETURN_STACK_DEPTH) fault_q = 1'b1;
                  else begin
                     rstk[rdepth] = pc;
                     rdepth++;
                  end
                  pc = label_addr(id);
               end
            end else begin
               case (opc)
                  OPC_MOV:   vm_write(vm_read(0));
                  OPC_LABEL: void'(vm_fetch());
                  OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_CMP, OPC_AND, OPC_OR,
                  OPC_XOR: begin
                     a = vm_read(0);
                     b = vm_read(0);
                     case (opc)
                        OPC_ADD: vm_write(a + b);
                        OPC_SUB: vm_write(a - b);
                        OPC_MUL: vm_write(a * b);
                        OPC_DIV: vm_write(signed_quot(a, b));
                        OPC_CMP: cmp_reg = a - b;
                        OPC_AND: vm_write(a & b);
                        OPC_OR:  vm_write(a | b);
                        default: vm_write(a ^ b);
                     endcase
                  end
                  OPC_NOT: begin
                     a = vm_read(0);
                     vm_write(a == 0 ? 32'd1 : 32'd0);
                  end
                  OPC_RET: begin
                     if (rdepth == 0) begin
                        fault_q = 1'b1;
                        pc = 0;
                     end else begin
                        rdepth--;
                        pc = rstk[rdepth];
                     end
                  end
                  OPC_EXIT:  halted_q = 1'b1;
                  OPC_PRINT: begin
                     r.print_value = vm_read(0);
                     r.printed = 1'b1;
                  end
                  OPC_INPUT: begin
                     r.took_input = 1'b1;
                     vm_write(w);
                  end
                  default: ;
               endcase
            end
         end
      end
      r.halted = halted_q;
      r.fault = fault_q;
      return r;
   endfunction

   // ---------------------------------------------------------------- driving
   task automatic send_word(logic op, word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(vm_execute_word(op, w));
      if (op == LOAD_OP) n_loads++;
      else n_steps++;
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      vm_result_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            e = expected_results.pop_front();
            n_checked++;
            if (rsp_tdata[0] !== e.printed) begin
               $error("printed: expected %0d, got %0d", e.printed, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[32:1] !== e.print_value) begin
               $error("print_value: expected %h, got %h", e.print_value, rsp_tdata[32:1]);
               errors++;
            end
            if (rsp_tdata[33] !== e.took_input) begin
               $error("took_input: expected %0d, got %0d", e.took_input, rsp_tdata[33]);
               errors++;
            end
            if (rsp_tdata[34] !== e.halted) begin
               $error("halted: expected %0d, got %0d", e.halted, rsp_tdata[34]);
               errors++;
            end
            if (rsp_tdata[35] !== e.fault) begin
               $error("fault: expected %0d, got %0d", e.fault, rsp_tdata[35]);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- program building
   function automatic word_type rand_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hffff_ffff;
         3: return 32'h8000_0000;
         4: return 32'h7fff_ffff;
         5: return $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   function automatic word_type rand_addr();
      case ($urandom_range(3))
         0: return 0;
         1: return DATA_WORDS - 1;
         default: return $urandom_range(DATA_WORDS - 1);
      endcase
   endfunction

   function automatic word_type new_label();
      label_seq++;
      return 100 + (label_seq % 156);
   endfunction

   function automatic void add_src(ref word_type q[$], input bit regs_only);
      word_type a;
      case (regs_only ? $urandom_range(3) : $urandom_range(9))
         0: q.push_back(KIND_R1);
         1: q.push_back(KIND_R2);
         2: q.push_back(KIND_CMPR);
         4: begin
            q.push_back(KIND_MEM);
            q.push_back(rand_addr());
         end
         5: begin
            if (gen_stack > 0) begin
               q.push_back(KIND_STACK);
               gen_stack--;
            end else q.push_back(KIND_R2);
         end
         6: begin
            q.push_back(KIND_PTR);
            q.push_back(KIND_CONST);
            q.push_back(rand_addr());
         end
         7: begin
            // two-level pointer only where the inner word is a valid address
            a = rand_addr();
            if (dmem[a] < DATA_WORDS) begin
               q.push_back(KIND_PTR);
               q.push_back(KIND_PTR);
               q.push_back(KIND_CONST);
            end else q.push_back(KIND_MEM);
            q.push_back(a);
         end
         8: q.push_back(KIND_BAD);
         default: begin
            q.push_back(KIND_CONST);
            q.push_back(rand_word());
         end
      endcase
   endfunction

   function automatic void add_dst(ref word_type q[$], input bit regs_only);
      case (regs_only ? $urandom_range(2) : $urandom_range(8))
         0: q.push_back(KIND_R1);
         1: q.push_back(KIND_R2);
         2: q.push_back(KIND_CMPR);
         3: begin
            q.push_back(KIND_MEM);
            q.push_back(rand_addr());
         end
         4: begin
            if (gen_stack < OPERAND_STACK_DEPTH - 6) begin
               q.push_back(KIND_STACK);
               gen_stack++;
            end else q.push_back(KIND_R1);
         end
         5: begin
            q.push_back(KIND_PTR);
            q.push_back(KIND_CONST);
            q.push_back(rand_addr());
         end
         6: q.push_back(KIND_BAD);
         7: q.push_back(KIND_CONST);
         default: q.push_back(KIND_R1);
      endcase
   endfunction

   function automatic void add_instr(ref word_type q[$], input bit regs_only);
      word_type b;
      case ($urandom_range(15))
         0, 1: begin
            q.push_back(OPC_MOV);
            add_src(q, regs_only);
            add_dst(q, regs_only);
         end
         2, 3, 4: begin
            case ($urandom_range(5))
               0: q.push_back(OPC_ADD);
               1: q.push_back(OPC_SUB);
               2: q.push_back(OPC_MUL);
               3: q.push_back(OPC_AND);
               4: q.push_back(OPC_OR);
               default: q.push_back(OPC_XOR);
            endcase
            add_src(q, regs_only);
            add_src(q, regs_only);
            add_dst(q, regs_only);
         end
         5: begin
            q.push_back(OPC_CMP);
            add_src(q, regs_only);
            add_src(q, regs_only);
         end
         6: begin
            b = rand_word();
            q.push_back(OPC_DIV);
            add_src(q, regs_only);
            q.push_back(KIND_CONST);
            q.push_back(b == 0 ? 32'd7 : b);
            add_dst(q, regs_only);
         end
         7: begin
            q.push_back(OPC_NOT);
            add_src(q, regs_only);
            add_dst(q, regs_only);
         end
         8, 9: begin
            q.push_back(OPC_PRINT);
            add_src(q, regs_only);
         end
         10, 11: begin
            q.push_back(OPC_INPUT);
            add_dst(q, regs_only);
         end
         12: q.push_back(OPC_NATIVE);
         13: q.push_back(OPC_UNKNOWN + $urandom_range(3));
         default: begin
            // label ids below the jump range, or out of range entirely
            q.push_back(OPC_LABEL);
            q.push_back($urandom_range(1) ? $urandom_range(99) : $urandom_range(9999) + 256);
         end
      endcase
   endfunction

   task automatic run_program(word_type q[$]);
      int guard;
      guard = 0;
      if (q[$] == OPC_LABEL) q.push_back(OPC_NATIVE);
      foreach (q[i]) send_word(LOAD_OP, q[i]);
      while (!halted_q && !fault_q && pc < pm_len && guard < 40) begin
         send_word(STEP_OP, rand_word());
         guard++;
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      // four-level pointer chain through address 0 while memory is still clear
      run_program({OPC_PRINT, KIND_PTR, KIND_PTR, KIND_PTR, KIND_PTR, KIND_CONST, 32'd0});
      run_program({OPC_MOV, KIND_CONST, 32'h7fff_ffff, KIND_R1});
      run_program({OPC_ADD, KIND_R1, KIND_CONST, 32'd1, KIND_R2});
      run_program({OPC_DIV, KIND_R2, KIND_CONST, 32'hffff_ffff, KIND_MEM, 32'd0});
      run_program({OPC_MUL, KIND_MEM, 32'd0, KIND_CONST, 32'hffff_ffff,
                   KIND_MEM, DATA_WORDS - 1});
      run_program({OPC_DIV, KIND_CONST, 32'hffff_fff9, KIND_CONST, 32'd2, KIND_STACK});
      run_program({OPC_SUB, KIND_STACK, KIND_CONST, 32'h8000_0000, KIND_CMPR});
      run_program({OPC_CMP, KIND_R1, KIND_R2});
      run_program({OPC_NOT, KIND_CMPR, KIND_R1, OPC_NOT, KIND_CONST, 32'd0, KIND_R2});
      run_program({OPC_INPUT, KIND_R1, OPC_INPUT, KIND_MEM, 32'd5});
      run_program({OPC_PRINT, KIND_MEM, 32'd5, OPC_PRINT, KIND_BAD});
      run_program({OPC_MOV, KIND_CONST, 32'd9, KIND_BAD, OPC_MOV, KIND_R1, KIND_CONST});
      run_program({OPC_UNKNOWN, OPC_NATIVE, OPC_LABEL, 32'd42});
      run_program({OPC_AND, KIND_R1, KIND_CONST, 32'hf0f0_f0f0, KIND_R2,
                   OPC_OR, KIND_R2, KIND_R1, KIND_R1,
                   OPC_XOR, KIND_R1, KIND_CONST, 32'hffff_ffff, KIND_PTR, KIND_CONST, 32'd3});
   endtask

   task automatic test_random();
      word_type q[$];
      word_type lt, lm;
      while (pm_len < 960 && !halted_q && !fault_q) begin
         if (pm_len < 330) begin
            send_idle_pct = 7;
            recv_idle_pct = 77;
         end else if (pm_len < 660) begin
            send_idle_pct = 77;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         gen_stack = odepth;
         q = {};
         case ($urandom_range(9))
            6, 7: begin
               // forward conditional jump over one instruction
               lt = new_label();
               q.push_back(OPC_JMP + $urandom_range(6));
               q.push_back(lt);
               add_instr(q, 1'b1);
               q.push_back(OPC_LABEL);
               q.push_back(lt);
            end
            8, 9: begin
               // conditional call into a subroutine placed behind a jump
               lt = new_label();
               lm = new_label();
               q = {OPC_CAL + $urandom_range(6), lt, OPC_JMP, lm, OPC_LABEL, lt};
               add_instr(q, 1'b1);
               q.push_back(OPC_RET);
               q.push_back(OPC_LABEL);
               q.push_back(lm);
            end
            default: add_instr(q, 1'b0);
         endcase
         run_program(q);
      end
   endtask

   task automatic test_stop_and_fault();
      word_type q[$];
      send_idle_pct = 0;
      recv_idle_pct = 0;
      final_case = $urandom_range(8);
      case (final_case)
         0: q = {OPC_DIV, KIND_CONST, 32'd5, KIND_CONST, 32'd0, KIND_R1};
         1: q = {OPC_MOV, KIND_MEM, 32'hffff_ffff, KIND_R1, OPC_MOV, KIND_R1, KIND_MEM,
                 DATA_WORDS};
         2: q = {OPC_MOV, KIND_PTR, KIND_PTR, KIND_PTR, KIND_PTR, KIND_PTR, KIND_CONST,
                 32'd0, KIND_R1};
         3: q = {OPC_JMP, 32'd300};
         4: q = {OPC_RET};
         5: q = {OPC_EXIT};
         6: q = {OPC_LABEL};
         7: q = {};
         default: begin
            if (odepth < 30) repeat (odepth + 1) q = {q, OPC_PRINT, KIND_STACK};
            else q = {OPC_DIV, KIND_R1, KIND_CONST, 32'd0, KIND_R2};
         end
      endcase
      foreach (q[i]) send_word(LOAD_OP, q[i]);
      repeat (odepth + 4) send_word(STEP_OP, rand_word());
   endtask

   task automatic test_full_store();
      repeat (PROGRAM_DEPTH - pm_len + 4) send_word(LOAD_OP, rand_word());
      repeat (3) send_word(STEP_OP, rand_word());
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      int waited;
      pm_len = 0; pc = 0; odepth = 0; rdepth = 0;
      reg_a = '0; reg_b = '0; cmp_reg = '0;
      halted_q = 1'b0; fault_q = 1'b0;
      foreach (lbl_tab[i]) lbl_tab[i] = 0;
      foreach (dmem[i]) dmem[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random();
      test_stop_and_fault();
      test_full_store();
      @(negedge clock);
      req_tvalid <= 1'b0;

      waited = 0;
      while (expected_results.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         $display("register_stack_vm_core regression: fail");
         $finish;
      end else begin
         repeat (200) @(posedge clock);
         $display("ran %0d program words and %0d steps, %0d result words checked",
                  n_loads, n_steps, n_checked);
         $display("closing case %0d, halted %0d, fault %0d", final_case, halted_q, fault_q);
         if (errors == 0 && expected_results.size() == 0)
            $display("register_stack_vm_core regression: pass");
         else
            $display("register_stack_vm_core regression: fail");
         $finish;
      end
   end

   initial begin
      #20_000_000;
      $display("register_stack_vm_core regression: fail");
      $finish;
   end

endmodule

// File: register_stack_vm_core.f
rtl/rsvm_pkg.sv
rtl/rsvm_div.sv
rtl/register_stack_vm_core.sv
tb/tb_top.sv
